// File: hdl/gma_pkg.sv
`default_nettype none
package gma_pkg;

    localparam int MAX_WIDTH       = 1024;
    localparam int MAX_HEIGHT      = 1024;
    localparam int ANGLE_FRAC_BITS = 14;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int DIM_W  = 11;
    localparam int THR_W  = 8;
    localparam int PIX_W  = 8;
    localparam int ANG_W  = 15;
    localparam int SUM_W  = 2 * PIX_W + 1;
    localparam int CFG_IDX_W = 2;

    // CORDIC datapath: angle in Q(ZF), vector scaled up by 2^ZF
    localparam int ITERS = 40;
    localparam int ZF    = 44;
    localparam int Z_W   = ZF + 3;
    localparam int XY_W  = ZF + PIX_W + 4;
    localparam int RND_SH = ZF - ANGLE_FRAC_BITS;

    // side-pipeline stage numbers
    localparam int SQ_STG  = 0;
    localparam int MAG_STG = SQ_STG + 1 + PIX_W;
    localparam int AN_STG  = MAG_STG + 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_THRESH = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [PIX_W-1:0] gx;
        logic [PIX_W-1:0] gy;
        logic [SUM_W-1:0] sum;
        logic [PIX_W-1:0] root;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             above_ok;
        logic             test;
        logic             zero;
        logic             anchor;
    } side_t;

    typedef logic signed [XY_W-1:0] xy_t;
    typedef logic signed [Z_W-1:0]  z_t;

    function automatic z_t atan_q(input int i);
        real r;
        r = $atan(2.0 ** (-i)) * (2.0 ** ZF);
        return z_t'(longint'(r));
    endfunction

endpackage
`default_nettype wire

// File: hdl/gma_if.sv
`default_nettype none
interface gma_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] grad_x;
    logic [7:0] grad_y;

    modport source (output valid, output grad_x, output grad_y, input ready);
    modport sink   (input valid, input grad_x, input grad_y, output ready);
endinterface

interface gma_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  magnitude;
    logic [14:0] angle;
    logic        anchor_above;
    logic        anchor_valid;
    logic [9:0]  pixel_row;
    logic [9:0]  pixel_column;

    modport source (output valid, output magnitude, output angle, output anchor_above,
                    output anchor_valid, output pixel_row, output pixel_column,
                    input ready);
    modport sink   (input valid, input magnitude, input angle, input anchor_above,
                    input anchor_valid, input pixel_row, input pixel_column,
                    output ready);
endinterface
`default_nettype wire

// File: hdl/gradient_magnitude_angle_anchor.sv
// channel   dir  fields
// pix_in    in   grad_x, grad_y
// pix_out   out  magnitude, angle, anchor_above, anchor_valid, pixel_row, pixel_column
// cfg       in   cfg_we, cfg_index, cfg_data
//
// One item per cycle unless the output stalls; each result passes the input register,
// loaded at the accepting edge, 40 CORDIC stages, then the output register.
// Magnitude: square, then one root bit per stage.
// After reset a pass zeroes every line buffer entry; no item is taken meanwhile.
// A stall at the output freezes the whole pipe; items keep their place.
`default_nettype none
module gradient_magnitude_angle_anchor (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    gma_in_if.sink                           pix_in,
    gma_out_if.source                        pix_out,
    input  wire logic                        cfg_we,
    input  wire logic [1:0]                  cfg_index,
    input  wire logic [10:0]                 cfg_data
);
    import gma_pkg::*;

    localparam int NS = ITERS + 1;

    logic [DIM_W-1:0] width_reg, height_reg;
    logic [THR_W-1:0] thresh_reg;

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [COL_W:0]   clr_cnt_reg;
    logic             clr_done;

    logic             v_reg [NS];
    side_t            side_reg [NS];
    side_t            side_next [NS];
    xy_t              x_reg [NS], y_reg [NS];
    xy_t              x_next [NS], y_next [NS];
    z_t               z_reg [NS], z_next [NS];

    logic [2*PIX_W-1:0] mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] rd0_reg, rd1_reg;
    logic [PIX_W-1:0]   last_c_reg;

    logic               out_valid_reg;
    logic [7:0]         mag_out_reg;
    logic [14:0]        ang_out_reg;
    logic               anc_out_reg, avld_out_reg;
    logic [9:0]         row_out_reg, col_out_reg;

    logic               en, take;
    logic [DIM_W-1:0]   w_eff, h_eff;
    side_t              side_in;
    logic [PIX_W-1:0]   mag_an;
    logic               wr_en;
    logic [COL_W-1:0]   wr_addr;
    logic [2*PIX_W-1:0] wr_data;
    z_t                 z_rnd;

    assign en       = !out_valid_reg || pix_out.ready;
    assign clr_done = clr_cnt_reg[COL_W];
    assign pix_in.ready = en && clr_done;
    assign take     = pix_in.valid && pix_in.ready;

    always_comb
    begin
        if (width_reg < DIM_W'(3))
            w_eff = DIM_W'(3);
        else if (width_reg > DIM_W'(MAX_WIDTH))
            w_eff = DIM_W'(MAX_WIDTH);
        else
            w_eff = width_reg;
        if (height_reg < DIM_W'(3))
            h_eff = DIM_W'(3);
        else if (height_reg > DIM_W'(MAX_HEIGHT))
            h_eff = DIM_W'(MAX_HEIGHT);
        else
            h_eff = height_reg;
    end

    // raster position and border test at entry
    always_comb
    begin
        side_in          = '0;
        side_in.gx       = pix_in.grad_x;
        side_in.gy       = pix_in.grad_y;
        side_in.row      = row_reg;
        side_in.col      = col_reg;
        side_in.above_ok = (row_reg != '0);
        side_in.zero     = (pix_in.grad_x == '0) && (pix_in.grad_y == '0);
        side_in.test     = ({1'b0, row_reg} >= (ROW_W+1)'(2))
                        && ((DIM_W+1)'(row_reg) + (DIM_W+1)'(1) <= (DIM_W+1)'(h_eff))
                        && (col_reg != '0)
                        && ((DIM_W+1)'(col_reg) + (DIM_W+1)'(2) <= (DIM_W+1)'(w_eff));
        col_next = col_reg;
        row_next = row_reg;
        if ((DIM_W+1)'(col_reg) + (DIM_W+1)'(1) >= (DIM_W+1)'(w_eff))
        begin
            col_next = '0;
            if ((DIM_W+1)'(row_reg) + (DIM_W+1)'(1) >= (DIM_W+1)'(h_eff))
                row_next = '0;
            else
                row_next = row_reg + ROW_W'(1);
        end
        else
        begin
            col_next = col_reg + COL_W'(1);
        end
    end

    assign mag_an = side_reg[AN_STG].sum[SUM_W-1] ? '1 : side_reg[AN_STG].root;

    // stage logic: one CORDIC iteration per stage; side data per stage number
    always_comb
    begin
        logic [PIX_W-1:0] t;
        logic [PIX_W-1:0] c, up, right, left;
        logic [PIX_W:0]   lt, rt, ut, dt;
        c     = rd0_reg[2*PIX_W-1:PIX_W];
        up    = rd0_reg[PIX_W-1:0];
        right = rd1_reg[2*PIX_W-1:PIX_W];
        left  = last_c_reg;
        lt    = {1'b0, left}   + {1'b0, thresh_reg};
        rt    = {1'b0, right}  + {1'b0, thresh_reg};
        ut    = {1'b0, up}     + {1'b0, thresh_reg};
        dt    = {1'b0, mag_an} + {1'b0, thresh_reg};
        t     = '0;
        x_next[0]    = '0;
        y_next[0]    = '0;
        z_next[0]    = '0;
        side_next[0] = '0;
        for (int j = 0; j < ITERS; j++)
        begin
            if (!y_reg[j][XY_W-1])
            begin
                x_next[j+1] = x_reg[j] + (y_reg[j] >>> j);
                y_next[j+1] = y_reg[j] - (x_reg[j] >>> j);
                z_next[j+1] = z_reg[j] + atan_q(j);
            end
            else
            begin
                x_next[j+1] = x_reg[j] - (y_reg[j] >>> j);
                y_next[j+1] = y_reg[j] + (x_reg[j] >>> j);
                z_next[j+1] = z_reg[j] - atan_q(j);
            end
            side_next[j+1] = side_reg[j];
            if (j == SQ_STG)
            begin
                side_next[j+1].sum  = SUM_W'(side_reg[j].gx * side_reg[j].gx)
                                    + SUM_W'(side_reg[j].gy * side_reg[j].gy);
                side_next[j+1].root = '0;
            end
            else if (j > SQ_STG && j < MAG_STG)
            begin
                t = side_reg[j].root | PIX_W'(1 << (MAG_STG - 1 - j));
                if (SUM_W'(t * t) <= side_reg[j].sum)
                    side_next[j+1].root = t;
            end
            else if (j == AN_STG)
            begin
                side_next[j+1].anchor = side_reg[j].test
                    && ((({1'b0, c} >= lt) && ({1'b0, c} >= rt))
                     || (({1'b0, c} >= ut) && ({1'b0, c} >= dt)));
            end
        end
    end

    // line buffer: entry holds {row-1, row-2} magnitudes of a column
    always_comb
    begin
        if (!clr_done)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_cnt_reg[COL_W-1:0];
            wr_data = '0;
        end
        else
        begin
            wr_en   = en && v_reg[AN_STG];
            wr_addr = side_reg[AN_STG].col;
            wr_data = {mag_an, rd0_reg[2*PIX_W-1:PIX_W]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (en)
        begin
            rd0_reg <= mem[side_reg[MAG_STG].col];
            rd1_reg <= mem[side_reg[MAG_STG].col + COL_W'(1)];
        end
        if (en && v_reg[AN_STG])
            last_c_reg <= rd0_reg[2*PIX_W-1:PIX_W];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_in;
            x_reg[0]    <= xy_t'({pix_in.grad_x, ZF'(0)});
            y_reg[0]    <= xy_t'({pix_in.grad_y, ZF'(0)});
            z_reg[0]    <= '0;
            for (int j = 1; j < NS; j++)
            begin
                side_reg[j] <= side_next[j];
                x_reg[j]    <= x_next[j];
                y_reg[j]    <= y_next[j];
                z_reg[j]    <= z_next[j];
            end
        end
    end

    assign z_rnd = (z_reg[NS-1] + z_t'(longint'(1) << (RND_SH - 1))) >>> RND_SH;

    always_ff @(posedge clk)
    begin
        if (en && v_reg[NS-1])
        begin
            mag_out_reg  <= side_reg[NS-1].sum[SUM_W-1] ? '1 : side_reg[NS-1].root;
            ang_out_reg  <= side_reg[NS-1].zero ? '0 : z_rnd[ANG_W-1:0];
            anc_out_reg  <= side_reg[NS-1].anchor;
            avld_out_reg <= side_reg[NS-1].above_ok;
            row_out_reg  <= side_reg[NS-1].row;
            col_out_reg  <= side_reg[NS-1].col;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= DIM_W'(640);
            height_reg    <= DIM_W'(480);
            thresh_reg    <= THR_W'(8);
            col_reg       <= '0;
            row_reg       <= '0;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            for (int j = 0; j < NS; j++)
                v_reg[j] <= 1'b0;
        end
        else
        begin
            if (!clr_done)
                clr_cnt_reg <= clr_cnt_reg + (COL_W+1)'(1);
            if (cfg_we)
            begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_WIDTH:  width_reg  <= cfg_data;
                    CFG_HEIGHT: height_reg <= cfg_data;
                    CFG_THRESH: thresh_reg <= cfg_data[THR_W-1:0];
                    default:    ;
                endcase
            end
            if (take)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (en)
            begin
                v_reg[0] <= take;
                for (int j = 1; j < NS; j++)
                    v_reg[j] <= v_reg[j-1];
                out_valid_reg <= v_reg[NS-1];
            end
        end
    end

    assign pix_out.valid        = out_valid_reg;
    assign pix_out.magnitude    = mag_out_reg;
    assign pix_out.angle        = ang_out_reg;
    assign pix_out.anchor_above = anc_out_reg;
    assign pix_out.anchor_valid = avld_out_reg;
    assign pix_out.pixel_row    = row_out_reg;
    assign pix_out.pixel_column = col_out_reg;

endmodule
`default_nettype wire

// File: tb/gradient_magnitude_angle_anchor_checker.sv
`timescale 1ns / 1ps
module gradient_magnitude_angle_anchor_checker (
    input  logic        clk,
    input  logic        rst_n,
    gma_in_if           in_ch,
    gma_out_if          out_ch,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_data,
    output int          fail_count,
    output int          pending
);
    import gma_pkg::*;

    typedef struct packed {
        logic [7:0]  magnitude;
        logic [14:0] angle;
        logic        anchor_above;
        logic        anchor_valid;
        logic [9:0]  row;
        logic [9:0]  column;
    } pixel_result_t;

    localparam longint unsigned Q60_ONE = 64'd1 << 60;

    pixel_result_t   result_q[$];
    logic [7:0]      mag_row1 [MAX_WIDTH];
    logic [7:0]      mag_row2 [MAX_WIDTH];
    int              col_cnt;
    int              row_cnt;
    logic [10:0]     width_reg;
    logic [10:0]     height_reg;
    logic [7:0]      thr_reg;
    longint unsigned quarter_pi;

    function automatic longint unsigned ratio_floor(longint unsigned v, longint unsigned p,
                                                    longint unsigned q);
        return (v / q) * p + ((v % q) * p) / q;
    endfunction

    // arctan(a/b) in Q60, valid for a <= b/2
    function automatic longint unsigned arctan_q60(longint unsigned a, longint unsigned b);
        longint unsigned pw, pos, neg;
        pw  = ratio_floor(Q60_ONE, a, b);
        pos = 0;
        neg = 0;
        for (int n = 0; n < 80 && pw != 0; n++)
        begin
            if ((n & 1) == 0)
                pos += pw / longint'(2 * n + 1);
            else
                neg += pw / longint'(2 * n + 1);
            pw = ratio_floor(pw, a * a, b * b);
        end
        return pos - neg;
    endfunction

    function automatic logic [14:0] angle_q14(int gx, int gy);
        longint unsigned v;
        int mn, mx;
        if (gx == 0 && gy == 0)
            return '0;
        mn = gx < gy ? gx : gy;
        mx = gx < gy ? gy : gx;
        if (2 * mn <= mx)
            v = arctan_q60(mn, mx);
        else
            v = quarter_pi - arctan_q60(mx - mn, mx + mn);
        if (gy > gx)
            v = 2 * quarter_pi - v;
        v = (v + (64'd1 << 45)) >> 46;
        return v[14:0];
    endfunction

    function automatic int isqrt_sat(int gx, int gy);
        int s, r;
        s = gx * gx + gy * gy;
        r = 0;
        if (s >= 65536)
            return 255;
        for (int b = 128; b != 0; b = b >> 1)
        begin
            if ((r | b) * (r | b) <= s)
                r = r | b;
        end
        return r;
    endfunction

    function automatic int clamp_dim(int v, int hi);
        if (v < 3)
            return 3;
        return v > hi ? hi : v;
    endfunction

    initial
    begin
        quarter_pi = 4 * arctan_q60(1, 5) - arctan_q60(1, 239);
    end

    always @(posedge clk or negedge rst_n)
    begin : track
        pixel_result_t exp_r, got_r;
        int w, h, row, col, mag, c, lf, rt, up, dn, th, gx, gy;
        logic anchor;
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_WIDTH; i++)
            begin
                mag_row1[i] = '0;
                mag_row2[i] = '0;
            end
            col_cnt    = 0;
            row_cnt    = 0;
            width_reg  = 11'd640;
            height_reg = 11'd480;
            thr_reg    = 8'd8;
            result_q.delete();
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_WIDTH:  width_reg  = cfg_data;
                    CFG_HEIGHT: height_reg = cfg_data;
                    CFG_THRESH: thr_reg    = cfg_data[7:0];
                    default: ;
                endcase
            end
            if (out_ch.valid && out_ch.ready)
            begin
                got_r = '{out_ch.magnitude, out_ch.angle, out_ch.anchor_above,
                          out_ch.anchor_valid, out_ch.pixel_row, out_ch.pixel_column};
                if (result_q.size() == 0)
                begin
                    $display("%0t unexpected item: expected none actual %p", $time, got_r);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_r = result_q.pop_front();
                    if (exp_r != got_r)
                    begin
                        if (exp_r.magnitude != got_r.magnitude)
                            $display("%0t magnitude expected %0d actual %0d", $time,
                                     exp_r.magnitude, got_r.magnitude);
                        if (exp_r.angle != got_r.angle)
                            $display("%0t angle expected %0d actual %0d", $time,
                                     exp_r.angle, got_r.angle);
                        if (exp_r.anchor_above != got_r.anchor_above)
                            $display("%0t anchor_above expected %0d actual %0d", $time,
                                     exp_r.anchor_above, got_r.anchor_above);
                        if (exp_r.anchor_valid != got_r.anchor_valid)
                            $display("%0t anchor_valid expected %0d actual %0d", $time,
                                     exp_r.anchor_valid, got_r.anchor_valid);
                        if (exp_r.row != got_r.row)
                            $display("%0t pixel_row expected %0d actual %0d", $time,
                                     exp_r.row, got_r.row);
                        if (exp_r.column != got_r.column)
                            $display("%0t pixel_column expected %0d actual %0d", $time,
                                     exp_r.column, got_r.column);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (in_ch.valid && in_ch.ready)
            begin
                gx     = int'(in_ch.grad_x);
                gy     = int'(in_ch.grad_y);
                w      = clamp_dim(int'(width_reg), MAX_WIDTH);
                h      = clamp_dim(int'(height_reg), MAX_HEIGHT);
                th     = int'(thr_reg);
                row    = row_cnt;
                col    = col_cnt;
                mag    = isqrt_sat(gx, gy);
                anchor = 1'b0;
                if (row >= 2 && row <= h - 1 && col >= 1 && col + 2 <= w)
                begin
                    c  = int'(mag_row1[col]);
                    lf = int'(mag_row2[col - 1]);
                    rt = int'(mag_row1[col + 1]);
                    up = int'(mag_row2[col]);
                    dn = mag;
                    if (c - lf >= th && c - rt >= th)
                        anchor = 1'b1;
                    if (c - up >= th && c - dn >= th)
                        anchor = 1'b1;
                end
                mag_row2[col] = mag_row1[col];
                mag_row1[col] = mag[7:0];
                exp_r.magnitude    = mag[7:0];
                exp_r.angle        = angle_q14(gx, gy);
                exp_r.anchor_above = anchor;
                exp_r.anchor_valid = row > 0;
                exp_r.row          = row[9:0];
                exp_r.column       = col[9:0];
                result_q.insert(result_q.size(), exp_r);
                if (col + 1 >= w)
                begin
                    col_cnt = 0;
                    row_cnt = (row + 1 >= h) ? 0 : row + 1;
                end
                else
                    col_cnt = col + 1;
            end
            pending <= result_q.size();
        end
    end
endmodule

// File: tb/gradient_magnitude_angle_anchor_tb.sv
`timescale 1ns / 1ps
module gradient_magnitude_angle_anchor_tb;
    import gma_pkg::*;

    localparam logic [1:0] CFG_SPARE   = 2'd3;
    localparam int         CYCLE_LIMIT = 600000;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [10:0] cfg_data;
    int          fail_count;
    int          pending;
    int          cycles;
    int          burst_left;
    bit          hold_req;

    gma_in_if  in_ch ();
    gma_out_if out_ch ();

    gradient_magnitude_angle_anchor dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_in    (in_ch),
        .pix_out   (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    gradient_magnitude_angle_anchor_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("gradient_magnitude_angle_anchor test failed");
            $finish;
        end
    end

    // receiver stall pattern, plus one long hold-off on request
    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            if (hold_req)
            begin
                out_ch.ready <= 1'b0;
                repeat (400) @(posedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                case ($urandom % 4)
                    0:
                    begin
                        out_ch.ready <= 1'b1;
                        repeat ($urandom_range(1, 40)) @(posedge clk);
                    end
                    1:
                    begin
                        out_ch.ready <= 1'b0;
                        repeat ($urandom_range(1, 6)) @(posedge clk);
                    end
                    default:
                        repeat ($urandom_range(1, 20))
                        begin
                            out_ch.ready <= 1'($urandom % 2);
                            @(posedge clk);
                        end
                endcase
            end
        end
    end

    function automatic logic [7:0] random_grad();
        case ($urandom % 4)
            0:       return 8'($urandom_range(0, 255));
            1:       return 8'd0;
            2:       return 8'($urandom_range(0, 8));
            default: return 8'($urandom_range(200, 255));
        endcase
    endfunction

    task automatic send_pixel(input logic [7:0] gx, input logic [7:0] gy);
        in_ch.valid  <= 1'b1;
        in_ch.grad_x <= gx;
        in_ch.grad_y <= gy;
        do
            @(posedge clk);
        while (!in_ch.ready);
        burst_left--;
        if (burst_left <= 0)
        begin
            in_ch.valid <= 1'b0;
            if ($urandom % 8 == 0)
                repeat ($urandom_range(5, 30)) @(posedge clk);
            else
                repeat ($urandom_range(1, 3)) @(posedge clk);
            burst_left = $urandom_range(1, 40);
        end
    endtask

    // stop sending and let every outstanding item drain
    task automatic drain();
        if (in_ch.valid)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        while (pending != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    task automatic set_frame(input logic [10:0] w, input logic [10:0] h,
                             input logic [7:0] thr);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_WIDTH;
        cfg_data  <= w;
        @(posedge clk);
        cfg_index <= CFG_HEIGHT;
        cfg_data  <= h;
        @(posedge clk);
        cfg_index <= CFG_THRESH;
        cfg_data  <= {3'($urandom), thr};
        @(posedge clk);
        cfg_index <= CFG_SPARE;
        cfg_data  <= 11'($urandom);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        logic [10:0] w, h;
        logic [7:0]  thr;
        int          n;
        rst_n        = 1'b0;
        cycles       = 0;
        hold_req     = 1'b0;
        burst_left   = 20;
        cfg_we       = 1'b0;
        cfg_index    = CFG_WIDTH;
        cfg_data     = '0;
        in_ch.valid  = 1'b0;
        in_ch.grad_x = '0;
        in_ch.grad_y = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // 3x3 frame, lone peak at the center, top threshold
        set_frame(11'd3, 11'd3, 8'd255);
        for (int i = 0; i < 9; i++)
        begin
            if (i == 4)
                send_pixel(8'd255, 8'd255);
            else
                send_pixel(8'd0, 8'd0);
        end
        // zero threshold: equal neighbours still count; extreme gradients
        set_frame(11'd3, 11'd3, 8'd0);
        send_pixel(8'd255, 8'd0);
        send_pixel(8'd0, 8'd255);
        send_pixel(8'd1, 8'd2);
        send_pixel(8'd2, 8'd1);
        send_pixel(8'd180, 8'd180);
        send_pixel(8'd3, 8'd4);
        send_pixel(8'd255, 8'd1);
        send_pixel(8'd1, 8'd255);
        send_pixel(8'd255, 8'd255);

        for (int p = 0; p < 10; p++)
        begin
            w   = 11'($urandom_range(3, 16));
            h   = 11'($urandom_range(3, 10));
            thr = (p % 3 == 0) ? 8'd0 : (p % 3 == 1) ? 8'd255 : 8'($urandom_range(0, 40));
            n   = 60;
            if (p == 2)
            begin
                w   = 11'd1024;
                h   = 11'd3;
                n   = 1100;
                thr = 8'd10;
            end
            else if (p == 3)
            begin
                w = 11'd0;
                h = 11'd1;
            end
            else if (p == 4)
            begin
                w = 11'd2047;
                h = 11'd2047;
            end
            else if (p == 7)
            begin
                w = 11'd1;
                h = 11'd2;
            end
            set_frame(w, h, thr);
            if (p == 5)
                hold_req = 1'b1;
            for (int i = 0; i < n; i++)
            begin
                if (p == 6 && i == n / 2)
                    drain();
                send_pixel(random_grad(), random_grad());
            end
        end

        drain();
        if (fail_count == 0)
            $display("gradient_magnitude_angle_anchor test passed");
        else
            $display("gradient_magnitude_angle_anchor test failed");
        $finish;
    end
endmodule
